// ===== sv/sha_pkg.sv =====
package sha_pkg;

   localparam logic ACTION_ABSORB = 1'b0;
   localparam logic ACTION_FINISH = 1'b1;

   localparam logic [7:0] PAD_MARK      = 8'h80;
   localparam logic [5:0] LENGTH_OFFSET = 6'd56;
   localparam logic [5:0] LAST_BYTE     = 6'd63;
   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [2:0] LAST_WORD     = 3'd7;

   typedef logic [7:0][31:0] word_array_type;
   typedef logic [15:0][31:0] sched_array_type;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic init;
   } core_ctrl_type;

   localparam word_array_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] v);
      return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] v);
      return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] v);
      return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] v);
      return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      case (idx)
         6'd0:  k = 32'h428a2f98;
         6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;
         6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;
         6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;
         6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;
         6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;
         6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;
         6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;
         6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;
         6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;
         6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;
         6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;
         6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;
         6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;
         6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;
         6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;
         6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;
         6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;
         6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;
         6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;
         6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;
         6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;
         6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;
         6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;
         6'd63: k = 32'hc67178f2;
         default: k = 32'h00000000;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/sha_block_buffer.sv =====
module sha_block_buffer (
   input  logic         clock,
   input  logic         shift_en,
   input  logic [7:0]   shift_byte,
   output logic [511:0] block
);

   logic [511:0] block_ff;
   logic [511:0] block_in;

   assign block_in = {block_ff[503:0], shift_byte};

   always_ff @(posedge clock) begin
      if (shift_en) begin
         block_ff <= block_in;
      end
   end

   assign block = block_ff;

endmodule

// ===== sv/sha_round_core.sv =====
module sha_round_core (
   input  logic                    clock,
   input  logic                    reset,
   input  sha_pkg::core_ctrl_type  ctrl,
   input  logic [511:0]            block,
   output logic                    done,
   output sha_pkg::word_array_type chain
);

   import sha_pkg::*;

   typedef enum logic [1:0] {
      C_IDLE,
      C_ROUND,
      C_ADD
   } core_state_type;

   core_state_type  state_ff;
   logic [5:0]      round_ff;
   logic            done_ff;
   word_array_type  chain_ff;
   word_array_type  work_ff;
   word_array_type  work_in;
   sched_array_type sched_ff;
   sched_array_type sched_in;
   sched_array_type sched_load;
   logic [31:0]     t1;
   logic [31:0]     t2;
   logic [31:0]     ch;
   logic [31:0]     maj;

   always_comb begin
      for (int t = 0; t < 16; t++) begin
         sched_load[t] = block[511 - 32 * t -: 32];
      end
   end

   always_comb begin
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + big_sigma1(work_ff[4]) + ch + round_k(round_ff) + sched_ff[0];
      t2  = big_sigma0(work_ff[0]) + maj;
      work_in[7] = work_ff[6];
      work_in[6] = work_ff[5];
      work_in[5] = work_ff[4];
      work_in[4] = work_ff[3] + t1;
      work_in[3] = work_ff[2];
      work_in[2] = work_ff[1];
      work_in[1] = work_ff[0];
      work_in[0] = t1 + t2;
      for (int i = 0; i < 15; i++) begin
         sched_in[i] = sched_ff[i + 1];
      end
      sched_in[15] = sched_ff[0] + small_sigma0(sched_ff[1]) + sched_ff[9]
                   + small_sigma1(sched_ff[14]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         round_ff <= '0;
         done_ff  <= 1'b0;
         chain_ff <= INIT_HASH;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            C_IDLE: begin
               if (ctrl.init) begin
                  chain_ff <= INIT_HASH;
               end
               if (ctrl.start) begin
                  work_ff  <= chain_ff;
                  sched_ff <= sched_load;
                  round_ff <= '0;
                  state_ff <= C_ROUND;
               end
            end
            C_ROUND: begin
               work_ff  <= work_in;
               sched_ff <= sched_in;
               round_ff <= round_ff + 6'd1;
               if (round_ff == LAST_ROUND) begin
                  state_ff <= C_ADD;
               end
            end
            C_ADD: begin
               for (int i = 0; i < 8; i++) begin
                  chain_ff[i] <= chain_ff[i] + work_ff[i];
               end
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: begin
               state_ff <= C_IDLE;
            end
         endcase
      end
   end

   assign done  = done_ff;
   assign chain = chain_ff;

endmodule

// ===== sv/sha_digest_out.sv =====
module sha_digest_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  sha_pkg::word_array_type digest,
   output logic                    busy,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output sha_pkg::rsp_type        rsp_data
);

   import sha_pkg::*;

   word_array_type words_ff;
   logic [2:0]     index_ff;
   logic           valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         index_ff <= '0;
      end else if (valid_ff && !rsp_stall) begin
         if (index_ff == LAST_WORD) begin
            valid_ff <= 1'b0;
         end else begin
            index_ff <= index_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         words_ff <= digest;
      end
   end

   assign busy                 = valid_ff;
   assign rsp_valid            = valid_ff;
   assign rsp_data.digest_word = words_ff[index_ff];
   assign rsp_data.word_index  = index_ff;
   assign rsp_data.last_word   = (index_ff == LAST_WORD);

endmodule

// ===== sv/sha256_stream_hasher.sv =====
// Absorb transfers are taken one per cycle while idle; the 64th byte of a
// block starts a compression of a load step, 64 rounds and an add step, in
// which no transfer is taken. A finish pads one byte per cycle outside
// compressions, runs one or two compressions, then hands eight digest words
// to the output register. The single round unit limits the byte rate.
// Synchronous reset restores the initial hash value and clears all counters.
module sha256_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp_data
);

   import sha_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PAD,
      S_COMPRESS,
      S_DIGEST
   } state_type;

   state_type      state_ff;
   state_type      after_ff;
   logic [5:0]     fill_ff;
   logic [63:0]    length_ff;
   logic           length_phase_ff;
   logic           start_ff;

   logic           accept;
   logic           shift_en;
   logic [7:0]     shift_byte;
   logic [7:0]     pad_byte;
   logic [63:0]    bit_length;
   logic [2:0]     length_sel;
   logic           out_load;
   logic           out_busy;
   logic           core_done;
   core_ctrl_type  core_ctrl;
   logic [511:0]   block;
   word_array_type chain;

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && (state_ff == S_IDLE);
   assign bit_length = {length_ff[60:0], 3'b000};
   assign length_sel = 3'd7 - fill_ff[2:0];

   always_comb begin
      if (length_phase_ff && (fill_ff >= LENGTH_OFFSET)) begin
         pad_byte = bit_length[{length_sel, 3'b000} +: 8];
      end else begin
         pad_byte = 8'h00;
      end
      if (accept) begin
         shift_byte = (req_data.action == ACTION_FINISH) ? PAD_MARK : req_data.data_byte;
      end else begin
         shift_byte = pad_byte;
      end
   end

   assign shift_en        = accept || (state_ff == S_PAD);
   assign out_load        = (state_ff == S_DIGEST) && !out_busy;
   assign core_ctrl.start = start_ff;
   assign core_ctrl.init  = out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         after_ff        <= S_IDLE;
         fill_ff         <= '0;
         length_ff       <= '0;
         length_phase_ff <= 1'b0;
         start_ff        <= 1'b0;
      end else begin
         start_ff <= shift_en && (fill_ff == LAST_BYTE);
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_data.action == ACTION_ABSORB) begin
                     length_ff <= length_ff + 64'd1;
                     if (fill_ff == LAST_BYTE) begin
                        fill_ff  <= '0;
                        after_ff <= S_IDLE;
                        state_ff <= S_COMPRESS;
                     end else begin
                        fill_ff <= fill_ff + 6'd1;
                     end
                  end else begin
                     if (fill_ff == LAST_BYTE) begin
                        fill_ff         <= '0;
                        length_phase_ff <= 1'b1;
                        after_ff        <= S_PAD;
                        state_ff        <= S_COMPRESS;
                     end else begin
                        fill_ff         <= fill_ff + 6'd1;
                        length_phase_ff <= (fill_ff < LENGTH_OFFSET);
                        state_ff        <= S_PAD;
                     end
                  end
               end
            end
            S_PAD: begin
               if (fill_ff == LAST_BYTE) begin
                  fill_ff         <= '0;
                  length_phase_ff <= 1'b1;
                  after_ff        <= length_phase_ff ? S_DIGEST : S_PAD;
                  state_ff        <= S_COMPRESS;
               end else begin
                  fill_ff <= fill_ff + 6'd1;
               end
            end
            S_COMPRESS: begin
               if (core_done) begin
                  state_ff <= after_ff;
               end
            end
            S_DIGEST: begin
               if (!out_busy) begin
                  length_ff       <= '0;
                  fill_ff         <= '0;
                  length_phase_ff <= 1'b0;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   sha_block_buffer u_buffer (
      .clock      (clock),
      .shift_en   (shift_en),
      .shift_byte (shift_byte),
      .block      (block)
   );

   sha_round_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (core_ctrl),
      .block (block),
      .done  (core_done),
      .chain (chain)
   );

   sha_digest_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (out_load),
      .digest    (chain),
      .busy      (out_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sv/sha_checker.sv =====
module sha_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sha_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sha_pkg::rsp_type rsp_data
);

   import sha_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result changed.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_word
      |=> rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("Digest words did not follow in order.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == LAST_WORD)))
      else $error("Last word flag does not match the word index.");

   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("Block not idle after reset.");

endmodule

bind sha256_stream_hasher sha_checker u_checker (.*);
